[hdl/sfae_pkg.sv]
package sfae_pkg;

    localparam int EQ_W   = 10;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [0:0] REG_FACTOR_MODE = 1'b0;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_ELIM = 1'b1;

    localparam logic FM_CHOL = 1'b0;
    localparam logic FM_LDLT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPIV   = 2'd2,
        ST_UNMAPPED = 2'd3
    } t_status;

endpackage

[hdl/symmetric_front_assemble_eliminate.sv]
// Symmetric frontal assembly and elimination engine (Cholesky or LDLt).
// Input channel (i_in_valid / o_in_ready) takes one item at a time: an add
// beat maps row and column equations to front slots and accumulates a Q16.16
// value into the packed upper triangle; an eliminate beat factors one
// equation out of the front. Output channel (o_out_valid / i_out_ready)
// carries one result beat per add, or the pivot term and every nonzero
// coupled term for an eliminate, with o_last on the final beat.
// Steps: an eliminate runs a bit-serial square root (Cholesky only), then
// scans the front slots, dividing with the bit-serial divider where the
// row entry is nonzero, then does a rank-one update through the store
// memory, an output scan and a clearing of the row over the slots in use.
// Reset: the slot counts and valid bits clear at once; a clearing pass then
// zeroes the equation map and the triangle store over max(GLOBAL_EQS,
// MAX_FRONT*(MAX_FRONT+1)/2) entries (2080 by default), with o_in_ready low.
// A stalled receiver holds the output register; the engine waits on it
// before the next beat and accepts a new item once back in idle.
module symmetric_front_assemble_eliminate
    import sfae_pkg::*;
#(
    parameter int MAX_FRONT  = 64,
    parameter int GLOBAL_EQS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_mode,
    input  logic [EQ_W-1:0]          i_row_eq,
    input  logic [EQ_W-1:0]          i_col_eq,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [EQ_W-1:0]          o_equation,
    output logic signed [DATA_W-1:0] o_coefficient,
    output logic [1:0]               o_status,
    output logic                     o_last,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int SW          = $clog2(MAX_FRONT);
    localparam int CW          = SW + 1;
    localparam int STORE_DEPTH = MAX_FRONT * (MAX_FRONT + 1) / 2;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int EW          = $clog2(GLOBAL_EQS);
    localparam int CLR_N       = (GLOBAL_EQS > STORE_DEPTH) ? GLOBAL_EQS : STORE_DEPTH;
    localparam int CLW         = $clog2(CLR_N);

    localparam logic [16:0]   EQ_LIM  = 17'(GLOBAL_EQS);
    localparam logic [CW-1:0] FRONT_N = CW'(MAX_FRONT);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOOK_R, S_LOOK_C, S_CHECK, S_MAP_R, S_POP_R,
        S_MAP_C, S_POP_C, S_ADD_RD, S_ADD_WB, S_PIVOT, S_SQRT, S_SC_RD,
        S_SC_CHK, S_DIV, S_DIV_END, S_UPD, S_EM_START, S_EM_RD, S_EM_CHK,
        S_ZERO, S_FREE, S_PUSH
    } t_state;

    function automatic logic [AW-1:0] f_tri(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW-1:0]     lo;
        logic [SW-1:0]     hi;
        logic [2*SW+1:0]   pr;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        pr = (2*SW+2)'(hi) * ((2*SW+2)'(hi) + (2*SW+2)'(1));
        return AW'(pr >> 1) + AW'(lo);
    endfunction

    function automatic logic signed [31:0] f_sat(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [63:0] f_trunc16(input logic signed [63:0] x);
        logic signed [63:0] b;
        b = x[63] ? 64'sd65535 : 64'sd0;
        return (x + b) >>> 16;
    endfunction

    function automatic logic signed [31:0] f_qsat(input logic [47:0] q, input logic neg);
        if (!neg)
            return (q > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
        else
            return (q > 48'h80000000) ? 32'sh80000000 : 32'(32'd0 - q[31:0]);
    endfunction

    // memories
    logic [SW:0]              r_eqm_mem [GLOBAL_EQS];
    logic [EQ_W-1:0]          r_eqs_mem [MAX_FRONT];
    logic [SW-1:0]            r_stk_mem [MAX_FRONT];
    logic signed [31:0]       r_st_mem  [STORE_DEPTH];
    logic signed [31:0]       r_pv_mem  [MAX_FRONT];

    logic [SW:0]              r_eqm_q;
    logic [EQ_W-1:0]          r_eqs_q;
    logic [SW-1:0]            r_stk_q;
    logic signed [31:0]       r_st_q;
    logic signed [31:0]       r_pva_q;
    logic signed [31:0]       r_pvb_q;

    t_state                   r_state;
    t_state                   r_after;
    logic                     r_factor_mode;
    logic                     r_mode;
    logic [EQ_W-1:0]          r_row;
    logic [EQ_W-1:0]          r_col;
    logic signed [31:0]       r_val;
    logic                     r_rv;
    logic                     r_cv;
    logic [SW-1:0]            r_rs;
    logic [SW-1:0]            r_cs;
    logic [CW-1:0]            r_free_cnt;
    logic [CW-1:0]            r_front_used;
    logic [MAX_FRONT-1:0]     r_slot_vld;
    logic [CLW-1:0]           r_clr;
    logic [CW-1:0]            r_i;
    logic signed [31:0]       r_d;
    logic [31:0]              r_rem;
    logic [47:0]              r_num;
    logic [31:0]              r_den;
    logic                     r_neg;
    logic [5:0]               r_dcnt;
    logic [47:0]              r_sx;
    logic [47:0]              r_sr;
    logic [47:0]              r_sb;
    logic [4:0]               r_scnt;
    logic                     r_any;
    logic [SW-1:0]            r_last_i;
    logic [5:0]               r_tcnt;
    logic [5:0]               r_ecnt;
    logic [SW-1:0]            r_ui;
    logic [SW-1:0]            r_uj;
    logic [AW-1:0]            r_base;
    logic                     r_iss;
    logic                     r_s1_v;
    logic [AW-1:0]            r_s1_idx;
    logic                     r_s2_v;
    logic [AW-1:0]            r_s2_idx;
    logic signed [63:0]       r_s2_prod;
    logic signed [31:0]       r_s2_old;
    logic                     r_s3_v;
    logic [AW-1:0]            r_s3_idx;
    logic signed [63:0]       r_s3_val;
    logic signed [31:0]       r_s3_old;
    logic [EQ_W-1:0]          r_res_eq;
    logic signed [31:0]       r_res_coef;
    t_status                  r_res_st;
    logic                     r_res_last;
    logic                     r_out_valid;
    logic [EQ_W-1:0]          r_o_eq;
    logic signed [31:0]       r_o_coef;
    t_status                  r_o_st;
    logic                     r_o_last;

    // combinational
    logic [EW-1:0]            eqm_ra;
    logic                     eqm_we;
    logic [EW-1:0]            eqm_wa;
    logic [SW:0]              eqm_wd;
    logic                     asg_en;
    logic [EQ_W-1:0]          asg_eq;
    logic [SW-1:0]            asg_slot;
    logic [AW-1:0]            st_ra;
    logic                     st_we;
    logic [AW-1:0]            st_wa;
    logic signed [31:0]       st_wd;
    logic [SW-1:0]            pva_ra;
    logic                     pv_we;
    logic signed [31:0]       pv_wd;
    logic                     stk_we;
    logic [SW-1:0]            stk_ra;
    logic                     accept;
    logic                     out_free;
    logic                     row_bad;
    logic                     col_bad;
    logic [1:0]               need;
    logic [CW:0]              avail;
    logic [SW-1:0]            q_slot;
    logic                     q_vld;
    logic [SW-1:0]            i_s;
    logic                     i_end;
    logic signed [63:0]       add_sum;
    logic signed [31:0]       add_sat;
    logic [47:0]              sq_sum;
    logic [47:0]              sq_nx;
    logic [47:0]              sq_nr;
    logic [32:0]              dv_sh;
    logic                     dv_ge;
    logic [31:0]              dv_nrem;
    logic signed [31:0]       div_v;
    logic                     sc_qual;
    logic signed [63:0]       s2_t;
    logic signed [63:0]       s3_t;
    logic                     upd_last;
    logic                     em_qual;
    logic                     cfg_we;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign row_bad  = {7'd0, i_row_eq} >= EQ_LIM;
    assign col_bad  = {7'd0, i_col_eq} >= EQ_LIM;
    assign q_vld    = r_eqm_q[SW];
    assign q_slot   = r_eqm_q[SW-1:0];
    assign i_s      = r_i[SW-1:0];
    assign i_end    = (r_i + CW'(1)) == r_front_used;
    assign need     = {1'b0, !r_rv} + {1'b0, (!q_vld && (r_col != r_row))};
    assign avail    = {1'b0, r_free_cnt} + {1'b0, FRONT_N - r_front_used};
    assign add_sum  = 64'(r_val) + 64'(r_st_q);
    assign add_sat  = f_sat(add_sum);
    assign sq_sum   = r_sr + r_sb;
    assign sq_nx    = (r_sx >= sq_sum) ? (r_sx - sq_sum) : r_sx;
    assign sq_nr    = (r_sx >= sq_sum) ? ((r_sr >> 1) + r_sb) : (r_sr >> 1);
    assign dv_sh    = {r_rem, r_num[47]};
    assign dv_ge    = dv_sh >= {1'b0, r_den};
    assign dv_nrem  = dv_ge ? 32'(dv_sh - {1'b0, r_den}) : dv_sh[31:0];
    assign div_v    = f_qsat(r_num, r_neg);
    assign sc_qual  = (i_s != r_rs) && r_slot_vld[i_s] && (div_v != 32'sd0)
                      && (r_tcnt < 6'd63);
    assign em_qual  = (i_s != r_rs) && r_slot_vld[i_s] && (r_pva_q != 32'sd0)
                      && (r_ecnt < 6'd63);
    assign s2_t     = f_trunc16(r_s2_prod);
    assign s3_t     = (r_factor_mode == FM_LDLT) ? f_trunc16(r_s3_val) : r_s3_val;
    assign upd_last = (r_ui == r_uj) && (({1'b0, r_uj} + CW'(1)) == r_front_used);
    assign cfg_we   = psel && penable && pwrite && (paddr[2] == REG_FACTOR_MODE);
    assign stk_ra   = SW'(r_free_cnt - CW'(1));

    always_comb begin
        asg_en   = 1'b0;
        asg_eq   = r_row;
        asg_slot = r_front_used[SW-1:0];
        case (r_state)
            S_MAP_R: begin
                asg_en = !r_rv && (r_free_cnt == '0);
            end
            S_POP_R: begin
                asg_en   = 1'b1;
                asg_slot = r_stk_q;
            end
            S_MAP_C: begin
                asg_en = (r_col != r_row) && !r_cv && (r_free_cnt == '0);
                asg_eq = r_col;
            end
            S_POP_C: begin
                asg_en   = 1'b1;
                asg_eq   = r_col;
                asg_slot = r_stk_q;
            end
            default: ;
        endcase
    end

    always_comb begin
        eqm_ra = (r_state == S_LOOK_C) ? EW'(r_col) : EW'(r_row);
        eqm_we = 1'b0;
        eqm_wa = EW'(asg_eq);
        eqm_wd = {1'b1, asg_slot};
        if (r_state == S_CLEAR) begin
            eqm_we = 32'(r_clr) < 32'(GLOBAL_EQS);
            eqm_wa = EW'(r_clr);
            eqm_wd = '0;
        end else if (r_state == S_FREE) begin
            eqm_we = 1'b1;
            eqm_wa = EW'(r_row);
            eqm_wd = '0;
        end else begin
            eqm_we = asg_en;
        end
    end

    always_comb begin
        case (r_state)
            S_LOOK_C: st_ra = f_tri(q_slot, q_slot);
            S_ADD_RD: st_ra = f_tri(r_rs, r_cs);
            S_SC_RD:  st_ra = f_tri(i_s, r_rs);
            default:  st_ra = r_base + AW'(r_ui);
        endcase
        st_we = 1'b0;
        st_wa = f_tri(i_s, r_rs);
        st_wd = '0;
        case (r_state)
            S_CLEAR: begin
                st_we = 32'(r_clr) < 32'(STORE_DEPTH);
                st_wa = AW'(r_clr);
            end
            S_ADD_WB: begin
                st_we = 1'b1;
                st_wa = f_tri(r_rs, r_cs);
                st_wd = add_sat;
            end
            S_UPD: begin
                st_we = r_s3_v;
                st_wa = r_s3_idx;
                st_wd = f_sat(64'(r_s3_old) - s3_t);
            end
            S_ZERO: begin
                st_we = 1'b1;
            end
            default: ;
        endcase
        pva_ra = (r_state == S_UPD) ? r_ui : i_s;
        pv_we  = ((r_state == S_SC_CHK) && (r_st_q == 32'sd0)) || (r_state == S_DIV_END);
        pv_wd  = (r_state == S_DIV_END) ? div_v : 32'sd0;
        stk_we = (r_state == S_FREE) && (r_free_cnt < FRONT_N);
    end

    always_ff @(posedge i_clk) begin
        if (eqm_we)
            r_eqm_mem[eqm_wa] <= eqm_wd;
        r_eqm_q <= r_eqm_mem[eqm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (asg_en)
            r_eqs_mem[asg_slot] <= asg_eq;
        r_eqs_q <= r_eqs_mem[i_s];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we)
            r_stk_mem[r_free_cnt[SW-1:0]] <= r_rs;
        r_stk_q <= r_stk_mem[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (st_we)
            r_st_mem[st_wa] <= st_wd;
        r_st_q <= r_st_mem[st_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pv_we)
            r_pv_mem[i_s] <= pv_wd;
        r_pva_q <= r_pv_mem[pva_ra];
        r_pvb_q <= r_pv_mem[r_uj];
    end

    always_ff @(posedge i_clk) begin
        // update pipeline payload
        r_s1_idx  <= r_base + AW'(r_ui);
        r_s2_idx  <= r_s1_idx;
        r_s2_prod <= r_pva_q * r_pvb_q;
        r_s2_old  <= r_st_q;
        r_s3_idx  <= r_s2_idx;
        r_s3_old  <= r_s2_old;
        r_s3_val  <= (r_factor_mode == FM_LDLT) ? (f_sat(s2_t) * r_d) : s2_t;

        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_after       <= S_IDLE;
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
            r_free_cnt    <= '0;
            r_front_used  <= '0;
            r_slot_vld    <= '0;
            r_factor_mode <= FM_CHOL;
            r_iss         <= 1'b0;
            r_s1_v        <= 1'b0;
            r_s2_v        <= 1'b0;
            r_s3_v        <= 1'b0;
        end else begin
            if (cfg_we)
                r_factor_mode <= pwdata[0];
            if (r_out_valid && i_out_ready && (r_state != S_PUSH))
                r_out_valid <= 1'b0;
            if (asg_en)
                r_slot_vld[asg_slot] <= 1'b1;

            r_s1_v <= (r_state == S_UPD) && r_iss;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLW'(1);
                    if (r_clr == CLW'(CLR_N - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_mode <= i_mode;
                        r_row  <= i_row_eq;
                        r_col  <= i_col_eq;
                        r_val  <= i_value;
                        if (row_bad || (i_mode == MODE_ADD && col_bad)) begin
                            r_res_eq   <= i_row_eq;
                            r_res_coef <= '0;
                            r_res_st   <= ST_UNMAPPED;
                            r_res_last <= 1'b1;
                            r_after    <= S_IDLE;
                            r_state    <= S_PUSH;
                        end else begin
                            r_state <= S_LOOK_R;
                        end
                    end
                end
                S_LOOK_R: r_state <= S_LOOK_C;
                S_LOOK_C: begin
                    r_rv <= q_vld;
                    r_rs <= q_slot;
                    if (r_mode == MODE_ADD) begin
                        r_state <= S_CHECK;
                    end else if (!q_vld) begin
                        r_res_eq   <= r_row;
                        r_res_coef <= '0;
                        r_res_st   <= ST_UNMAPPED;
                        r_res_last <= 1'b1;
                        r_after    <= S_IDLE;
                        r_state    <= S_PUSH;
                    end else begin
                        r_state <= S_PIVOT;
                    end
                end
                S_CHECK: begin
                    r_cv <= q_vld;
                    r_cs <= q_slot;
                    if ({{(CW-1){1'b0}}, need} > avail) begin
                        r_res_eq   <= r_row;
                        r_res_coef <= '0;
                        r_res_st   <= ST_FULL;
                        r_res_last <= 1'b1;
                        r_after    <= S_IDLE;
                        r_state    <= S_PUSH;
                    end else begin
                        r_state <= S_MAP_R;
                    end
                end
                S_MAP_R: begin
                    if (r_rv) begin
                        r_state <= S_MAP_C;
                    end else if (r_free_cnt != '0) begin
                        r_free_cnt <= r_free_cnt - CW'(1);
                        r_state    <= S_POP_R;
                    end else begin
                        r_rs         <= r_front_used[SW-1:0];
                        r_front_used <= r_front_used + CW'(1);
                        r_state      <= S_MAP_C;
                    end
                end
                S_POP_R: begin
                    r_rs    <= r_stk_q;
                    r_state <= S_MAP_C;
                end
                S_MAP_C: begin
                    if (r_col == r_row) begin
                        r_cs    <= r_rs;
                        r_state <= S_ADD_RD;
                    end else if (r_cv) begin
                        r_state <= S_ADD_RD;
                    end else if (r_free_cnt != '0) begin
                        r_free_cnt <= r_free_cnt - CW'(1);
                        r_state    <= S_POP_C;
                    end else begin
                        r_cs         <= r_front_used[SW-1:0];
                        r_front_used <= r_front_used + CW'(1);
                        r_state      <= S_ADD_RD;
                    end
                end
                S_POP_C: begin
                    r_cs    <= r_stk_q;
                    r_state <= S_ADD_RD;
                end
                S_ADD_RD: r_state <= S_ADD_WB;
                S_ADD_WB: begin
                    r_res_eq   <= r_row;
                    r_res_coef <= add_sat;
                    r_res_st   <= ST_OK;
                    r_res_last <= 1'b1;
                    r_after    <= S_IDLE;
                    r_state    <= S_PUSH;
                end
                S_PIVOT: begin
                    r_i    <= '0;
                    r_any  <= 1'b0;
                    r_tcnt <= '0;
                    if ((r_factor_mode == FM_CHOL && r_st_q <= 32'sd0)
                        || (r_factor_mode == FM_LDLT && r_st_q == 32'sd0)) begin
                        r_res_eq   <= r_row;
                        r_res_coef <= '0;
                        r_res_st   <= ST_BADPIV;
                        r_res_last <= 1'b1;
                        r_after    <= S_IDLE;
                        r_state    <= S_PUSH;
                    end else if (r_factor_mode == FM_LDLT) begin
                        r_d     <= r_st_q;
                        r_state <= S_SC_RD;
                    end else begin
                        r_sx    <= {r_st_q[31:0], 16'd0};
                        r_sr    <= '0;
                        r_sb    <= 48'd1 << 46;
                        r_scnt  <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_sx   <= sq_nx;
                    r_sr   <= sq_nr;
                    r_sb   <= r_sb >> 2;
                    r_scnt <= r_scnt + 5'd1;
                    if (r_scnt == 5'd23) begin
                        r_d     <= sq_nr[31:0];
                        r_state <= S_SC_RD;
                    end
                end
                S_SC_RD: r_state <= S_SC_CHK;
                S_SC_CHK: begin
                    if (r_st_q == 32'sd0) begin
                        if (i_end) begin
                            r_ui    <= '0;
                            r_uj    <= '0;
                            r_base  <= '0;
                            r_iss   <= 1'b1;
                            r_state <= S_UPD;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_SC_RD;
                        end
                    end else begin
                        r_den   <= r_d[31] ? 32'(32'd0 - r_d) : r_d;
                        r_num   <= {(r_st_q[31] ? 32'(32'd0 - r_st_q) : r_st_q), 16'd0};
                        r_rem   <= '0;
                        r_neg   <= r_st_q[31] ^ r_d[31];
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= dv_nrem;
                    r_num  <= {r_num[46:0], dv_ge};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd47)
                        r_state <= S_DIV_END;
                end
                S_DIV_END: begin
                    if (sc_qual) begin
                        r_any    <= 1'b1;
                        r_last_i <= i_s;
                        r_tcnt   <= r_tcnt + 6'd1;
                    end
                    if (i_end) begin
                        r_ui    <= '0;
                        r_uj    <= '0;
                        r_base  <= '0;
                        r_iss   <= 1'b1;
                        r_state <= S_UPD;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_SC_RD;
                    end
                end
                S_UPD: begin
                    if (r_iss) begin
                        if (upd_last) begin
                            r_iss <= 1'b0;
                        end else if (r_ui == r_uj) begin
                            r_ui   <= '0;
                            r_uj   <= r_uj + SW'(1);
                            r_base <= r_base + AW'(r_uj) + AW'(1);
                        end else begin
                            r_ui <= r_ui + SW'(1);
                        end
                    end else if (!r_s1_v && !r_s2_v && !r_s3_v) begin
                        r_state <= S_EM_START;
                    end
                end
                S_EM_START: begin
                    r_res_eq   <= r_row;
                    r_res_coef <= r_d;
                    r_res_st   <= ST_OK;
                    r_res_last <= !r_any;
                    r_after    <= r_any ? S_EM_RD : S_ZERO;
                    r_i        <= '0;
                    r_ecnt     <= '0;
                    r_state    <= S_PUSH;
                end
                S_EM_RD: r_state <= S_EM_CHK;
                S_EM_CHK: begin
                    if (em_qual) begin
                        r_res_eq   <= r_eqs_q;
                        r_res_coef <= r_pva_q;
                        r_res_st   <= ST_OK;
                        r_res_last <= (i_s == r_last_i);
                        r_ecnt     <= r_ecnt + 6'd1;
                        if (i_s == r_last_i) begin
                            r_i     <= '0;
                            r_after <= S_ZERO;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_after <= S_EM_RD;
                        end
                        r_state <= S_PUSH;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_EM_RD;
                    end
                end
                S_ZERO: begin
                    if (i_end)
                        r_state <= S_FREE;
                    else
                        r_i <= r_i + CW'(1);
                end
                S_FREE: begin
                    r_slot_vld[r_rs] <= 1'b0;
                    if (r_free_cnt < FRONT_N)
                        r_free_cnt <= r_free_cnt + CW'(1);
                    r_state <= S_IDLE;
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_eq      <= r_res_eq;
                        r_o_coef    <= r_res_coef;
                        r_o_st      <= r_res_st;
                        r_o_last    <= r_res_last;
                        r_state     <= r_after;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_equation    = r_o_eq;
    assign o_coefficient = r_o_coef;
    assign o_status      = r_o_st;
    assign o_last        = r_o_last;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_FACTOR_MODE) ? {31'd0, r_factor_mode} : 32'd0;

endmodule

[hdl/sfae_checker.sv]
module sfae_checker
    import sfae_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [DATA_W-1:0] o_coefficient,
    input logic [1:0]               o_status,
    input logic                     o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_coefficient)))
        else $error("output beat dropped or changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_last)
        else $error("error beat not marked last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL || o_status == ST_BADPIV
            || o_status == ST_UNMAPPED)) |-> (o_coefficient == '0))
        else $error("error beat carries a coefficient");

endmodule

bind symmetric_front_assemble_eliminate sfae_checker u_sfae_checker (.*);
